[sv/ert_pkg.sv]
package ert_pkg;

   localparam int MAX_THREADS = 16;
   localparam int COUNT_WIDTH = 16;
   localparam int BINS        = 3;

   localparam int IDX_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int CNT_W = $clog2(MAX_THREADS + 1);

   localparam logic [1:0] FUNC_ENTER  = 2'd0;
   localparam logic [1:0] FUNC_EXIT   = 2'd1;
   localparam logic [1:0] FUNC_RETIRE = 2'd2;
   localparam logic [1:0] FUNC_FLUSH  = 2'd3;

   typedef struct packed {
      logic [1:0] func;
      logic [3:0] thread;
   } req_type;

   typedef struct packed {
      logic        freed_valid;
      logic [1:0]  freed_epoch;
      logic [15:0] freed_count;
      logic        advanced;
      logic [1:0]  epoch_now;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic in_walk;
      logic walk;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic walk_start;
      logic flush_multi;
      logic walk_end;
      logic bin_nonempty;
      logic bin_last;
      logic out_free;
   } status_type;

endpackage

[sv/ert_ctrl.sv]
module ert_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ert_pkg::status_type sts,
   output ert_pkg::cmd_type    cmd
);
   import ert_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // No request is taken while reset holds the controller.
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.out_free) begin
               cmd.exec = 1'b1;
               if (sts.flush_multi) begin
                  state_in = ST_FLUSH;
               end else if (sts.walk_start) begin
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_WALK: begin
            cmd.in_walk = 1'b1;
            // A step that produces the result has to wait for the output slot.
            if (sts.out_free || !sts.walk_end) begin
               cmd.walk = 1'b1;
               if (sts.walk_end) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (sts.out_free || !sts.bin_nonempty) begin
               cmd.flush = 1'b1;
               if (sts.bin_nonempty && sts.bin_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[sv/ert_datapath.sv]
module ert_datapath (
   input  logic                clock,
   input  logic                reset,
   input  ert_pkg::req_type    req_data,
   input  ert_pkg::cmd_type    cmd,
   output ert_pkg::status_type sts,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ert_pkg::rsp_type    rsp_data
);
   import ert_pkg::*;

   req_type                req_ff;
   logic [1:0]             ge_ff, ge_in;
   logic [CNT_W-1:0]       kc_ff, kc_in;
   logic [CNT_W-1:0]       walk_ff, walk_in;
   logic [1:0]             bin_ff, bin_in;
   logic                   active_ff [MAX_THREADS];
   logic                   active_in [MAX_THREADS];
   logic [1:0]             epoch_ff [MAX_THREADS];
   logic [1:0]             epoch_in [MAX_THREADS];
   logic                   known_ff [MAX_THREADS];
   logic                   known_in [MAX_THREADS];
   logic [COUNT_WIDTH-1:0] bins_ff [BINS];
   logic [COUNT_WIDTH-1:0] bins_in [BINS];
   logic [3:0]             order_ff [MAX_THREADS];
   logic                   order_we;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   in_range;
   logic [IDX_W-1:0]       tidx;
   logic [IDX_W-1:0]       uidx;
   logic [IDX_W-1:0]       rd_idx;
   logic                   act_r;
   logic [1:0]             ep_r;
   logic                   known_t;
   logic [1:0]             ep_t;
   logic [1:0]             rbin;
   logic [1:0]             ge_next;
   logic                   walk_done;
   logic                   walk_stop;
   logic                   all_empty;
   logic [COUNT_WIDTH-1:0] fl_cnt;
   logic                   fl_last;
   logic [COUNT_WIDTH-1:0] adv_cnt;
   logic                   emit;

   always_comb begin
      in_range  = int'(req_ff.thread) < MAX_THREADS;
      tidx      = IDX_W'(req_ff.thread);
      uidx      = IDX_W'(order_ff[IDX_W'(walk_ff - CNT_W'(1))]);
      // One read port on the active and epoch tables, shared by the walk and the caller.
      rd_idx    = cmd.in_walk ? uidx : tidx;
      act_r     = active_ff[rd_idx];
      ep_r      = epoch_ff[rd_idx];
      known_t   = known_ff[tidx];
      ep_t      = known_t ? ep_r : 2'd0;
      rbin      = (ep_t == 2'd3) ? 2'd0 : ep_t;
      ge_next   = (ge_ff == 2'd2) ? 2'd0 : ge_ff + 2'd1;
      adv_cnt   = bins_ff[ge_next];
      walk_done = (walk_ff == '0);
      walk_stop = !walk_done && act_r && (ep_r != ge_ff);
      all_empty = (bins_ff[0] == '0) && (bins_ff[1] == '0) && (bins_ff[2] == '0);
      fl_cnt    = (bin_ff == 2'd3) ? '0 : bins_ff[bin_ff];
      case (bin_ff)
         2'd0:    fl_last = (bins_ff[1] == '0) && (bins_ff[2] == '0);
         2'd1:    fl_last = (bins_ff[2] == '0);
         default: fl_last = 1'b1;
      endcase

      sts.walk_start   = (req_ff.func == FUNC_EXIT) && in_range;
      sts.flush_multi  = (req_ff.func == FUNC_FLUSH) && !all_empty;
      sts.walk_end     = walk_done || walk_stop;
      sts.bin_nonempty = (fl_cnt != '0);
      sts.bin_last     = fl_last;
      sts.out_free     = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      ge_in     = ge_ff;
      kc_in     = kc_ff;
      walk_in   = walk_ff;
      bin_in    = bin_ff;
      active_in = active_ff;
      epoch_in  = epoch_ff;
      known_in  = known_ff;
      bins_in   = bins_ff;
      order_we  = 1'b0;
      emit      = 1'b0;
      rsp_in    = '0;
      rsp_in.epoch_now = ge_ff;
      rsp_in.last      = 1'b1;

      if (cmd.exec) begin
         bin_in = 2'd0;
         if (req_ff.func == FUNC_FLUSH) begin
            emit = all_empty;
         end else if (!in_range) begin
            emit = 1'b1;
         end else begin
            if (!known_t) begin
               known_in[tidx]  = 1'b1;
               active_in[tidx] = 1'b0;
               epoch_in[tidx]  = 2'd0;
               if (kc_ff < CNT_W'(MAX_THREADS)) begin
                  order_we = 1'b1;
                  kc_in    = kc_ff + CNT_W'(1);
               end
            end
            case (req_ff.func)
               FUNC_ENTER: begin
                  active_in[tidx] = 1'b1;
                  epoch_in[tidx]  = ge_ff;
                  emit            = 1'b1;
               end
               FUNC_EXIT: begin
                  active_in[tidx] = 1'b0;
                  walk_in         = kc_in;
               end
               default: begin
                  if (bins_ff[rbin] != {COUNT_WIDTH{1'b1}}) begin
                     bins_in[rbin] = bins_ff[rbin] + COUNT_WIDTH'(1);
                  end
                  emit = 1'b1;
               end
            endcase
         end
      end

      if (cmd.walk) begin
         if (walk_done) begin
            // Every registered thread agrees: release the oldest bin and advance.
            ge_in              = ge_next;
            bins_in[ge_next]   = '0;
            emit               = 1'b1;
            rsp_in.freed_valid = (adv_cnt != '0);
            rsp_in.freed_epoch = (adv_cnt != '0) ? ge_next : 2'd0;
            rsp_in.freed_count = 16'(adv_cnt);
            rsp_in.advanced    = 1'b1;
            rsp_in.epoch_now   = ge_next;
         end else if (walk_stop) begin
            emit = 1'b1;
         end else begin
            if (!act_r) begin
               epoch_in[uidx] = ge_ff;
            end
            walk_in = walk_ff - CNT_W'(1);
         end
      end

      if (cmd.flush) begin
         bin_in = bin_ff + 2'd1;
         if (fl_cnt != '0) begin
            bins_in[bin_ff]    = '0;
            emit               = 1'b1;
            rsp_in.freed_valid = 1'b1;
            rsp_in.freed_epoch = bin_ff;
            rsp_in.freed_count = 16'(fl_cnt);
            rsp_in.last        = fl_last;
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ge_ff        <= '0;
         kc_ff        <= '0;
         walk_ff      <= '0;
         bin_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_THREADS; i++) begin
            active_ff[i] <= 1'b0;
            epoch_ff[i]  <= '0;
            known_ff[i]  <= 1'b0;
         end
         for (int b = 0; b < BINS; b++) begin
            bins_ff[b] <= '0;
         end
      end else begin
         ge_ff        <= ge_in;
         kc_ff        <= kc_in;
         walk_ff      <= walk_in;
         bin_ff       <= bin_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         epoch_ff     <= epoch_in;
         known_ff     <= known_in;
         bins_ff      <= bins_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (order_we) begin
         order_ff[kc_ff[IDX_W-1:0]] <= req_ff.thread;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[sv/epoch_reclamation_tracker.sv]
// One request at a time; enter, retire and out-of-range requests each give one result, and exit
// walks up to K registered threads (at most 16) first. Flush gives one result per nonempty bin,
// one bin a cycle while the output is free, or a single empty result when every bin is empty.
// The exit walk visits one registered thread per cycle through a single table read port.
// Reset (synchronous, active high) clears the epoch, all thread state and the bin counters.
module epoch_reclamation_tracker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ert_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ert_pkg::rsp_type rsp_data
);
   import ert_pkg::*;

   cmd_type    cmd;
   status_type sts;

   ert_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ert_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[sv/ert_checker.sv]
module ert_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ert_pkg::rsp_type rsp_data
);
   import ert_pkg::*;

   // A held result must not change while it waits.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // The block works on one request at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.freed_valid |->
         rsp_data.freed_count == '0 && rsp_data.freed_epoch == 2'd0)
      else $error("empty result carries a bin or a count");

   a_epoch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.epoch_now != 2'd3 && rsp_data.freed_epoch != 2'd3)
      else $error("epoch out of range");

   a_advance_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.advanced |-> rsp_data.last)
      else $error("advancing result is not the last one");

endmodule

bind epoch_reclamation_tracker ert_checker u_ert_checker (.*);
